// ===== rtl/multimode_synth_filter_assert.svh =====
// ----------------------------------------------------------------------------
// multimode_synth_filter_assert.svh - assertion macros
// Implication checks used by the filter block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTIMODE_SYNTH_FILTER_ASSERT_SVH
`define MULTIMODE_SYNTH_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication
`define MSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define MSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/msf_pkg.sv =====
// ----------------------------------------------------------------------------
// msf_pkg - shared definitions of the multimode filter
// Widths, codes, clamp limits and the structs passed between modules.
// ----------------------------------------------------------------------------
package msf_pkg;

    // State-variable integrator width and derived datapath widths
    localparam int SVF_BITS  = 24;
    localparam int ACC_W     = SVF_BITS + 3;
    localparam int TAP_W     = ACC_W + 1;
    localparam int OUT_W     = 25;
    localparam int CMP_W     = ((TAP_W > OUT_W) ? TAP_W : OUT_W) + 1;
    localparam int X_W       = 16;
    localparam int COEF_W    = 8;
    localparam int RESO_W    = 8;
    localparam int MUL_B_W   = 10;
    localparam int PROD_W    = ACC_W + MUL_B_W + 1;
    localparam int LAD_W     = 10;
    localparam int CLIP_W    = 9;
    localparam int LAD_POLES = 4;
    localparam int CLIP_POLES = 2;
    localparam int STEP_W    = 3;

    // Shifts and limits
    localparam int COEF_SHIFT    = 8;
    localparam int CLIP_FB_SHIFT = 7;
    localparam int Q_MAX         = 255;

    localparam logic signed [ACC_W-1:0] SVF_HI =
        {{(ACC_W-SVF_BITS+1){1'b0}}, {(SVF_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SVF_LO =
        {{(ACC_W-SVF_BITS+1){1'b1}}, {(SVF_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] LAD_MIN  = ACC_W'(-256);
    localparam logic signed [ACC_W-1:0] LAD_MAX  = ACC_W'(255);
    localparam logic signed [ACC_W-1:0] CLIP_MIN = ACC_W'(-200);
    localparam logic signed [ACC_W-1:0] CLIP_MAX = ACC_W'(180);
    localparam logic signed [CMP_W-1:0] OUT_HI =
        {{(CMP_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] OUT_LO =
        {{(CMP_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // Last sequencer step of each model
    localparam logic [STEP_W-1:0] SVF_LAST  = STEP_W'(2);
    localparam logic [STEP_W-1:0] LAD_LAST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] CLIP_LAST = STEP_W'(2);

    // Model and response codes
    localparam logic [1:0] MODEL_SVF    = 2'd0;
    localparam logic [1:0] MODEL_LADDER = 2'd1;
    localparam logic [1:0] MODEL_CLIP   = 2'd2;
    localparam logic [1:0] RESP_LP      = 2'd0;
    localparam logic [1:0] RESP_HP      = 2'd1;
    localparam logic [1:0] RESP_BP      = 2'd2;
    localparam logic [1:0] RESP_NOTCH   = 2'd3;

    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // APB register map
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MODEL  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RESP   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_QFLOOR = 2'd2;
    localparam logic [7:0] QFLOOR_RESET = 8'd32;

    typedef struct packed {
        logic [1:0] model;
        logic [1:0] resp;
        logic [7:0] q_floor;
    } cfg_t;

    typedef struct packed {
        logic                     action;
        logic signed [X_W-1:0]    sample_in;
        logic [COEF_W-1:0]        cutoff_coef;
        logic [RESO_W-1:0]        resonance_amount;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] base;
        logic signed [ACC_W-1:0] a;
        logic [MUL_B_W-1:0]      b;
        logic                    sub;
        logic                    fb_shift;
    } alu_req_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_stat_t;

endpackage

// ===== rtl/msf_in_if.sv =====
// ----------------------------------------------------------------------------
// msf_in_if - sample request channel
// Valid/ready channel carrying one filter request.
// ----------------------------------------------------------------------------
interface msf_in_if;
    import msf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic signed [X_W-1:0] sample_in;
    logic [COEF_W-1:0]     cutoff_coef;
    logic [RESO_W-1:0]     resonance_amount;

    modport source (
        output valid, action, sample_in, cutoff_coef, resonance_amount,
        input  ready
    );

    modport sink (
        input  valid, action, sample_in, cutoff_coef, resonance_amount,
        output ready
    );
endinterface

// ===== rtl/msf_out_if.sv =====
// ----------------------------------------------------------------------------
// msf_out_if - filtered sample channel
// Valid/ready channel carrying one filtered output sample.
// ----------------------------------------------------------------------------
interface msf_out_if;
    import msf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;

    modport source (
        output valid, sample_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out,
        output ready
    );
endinterface

// ===== rtl/msf_alu.sv =====
// ----------------------------------------------------------------------------
// msf_alu - shared multiply, shift and accumulate unit
// res = base +/- floor((a * b) >> 7 or 8); used once per sequencer step.
// ----------------------------------------------------------------------------
module msf_alu (
    input  msf_pkg::alu_req_t                  req,
    output logic signed [msf_pkg::ACC_W-1:0]   res
);
    import msf_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;

    // Signed product with unsigned coefficient
    assign prod = req.a * $signed({1'b0, req.b});

    // Arithmetic shift gives floor division
    assign scaled = req.fb_shift ? (prod >>> CLIP_FB_SHIFT) : (prod >>> COEF_SHIFT);

    assign res = req.sub ? (req.base - ACC_W'(scaled)) : (req.base + ACC_W'(scaled));

endmodule

// ===== rtl/msf_core.sv =====
// ----------------------------------------------------------------------------
// msf_core - filter state and step sequencer
// Holds all model state and walks one request through the shared ALU.
// ----------------------------------------------------------------------------
module msf_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msf_pkg::cfg_t                     cfg,
    input  logic                              item_valid,
    input  msf_pkg::item_t                    item,
    output msf_pkg::core_stat_t               stat,
    output logic signed [msf_pkg::OUT_W-1:0]  res_data,
    input  logic                              res_ready
);
    import msf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [STEP_W-1:0]         last_step;
    logic                      clr_reg, clr_next;
    logic signed [X_W-1:0]     x_reg, x_next;
    logic [COEF_W-1:0]         c_reg, c_next;
    logic [RESO_W-1:0]         r_reg, r_next;
    logic signed [ACC_W-1:0]   tmp_reg, tmp_next;
    logic signed [SVF_BITS-1:0] low_reg, low_next;
    logic signed [SVF_BITS-1:0] band_reg, band_next;
    logic signed [LAD_W-1:0]   lad_reg [LAD_POLES];
    logic signed [LAD_W-1:0]   lad_next [LAD_POLES];
    logic signed [CLIP_W-1:0]  clip_reg [CLIP_POLES];
    logic signed [CLIP_W-1:0]  clip_next [CLIP_POLES];

    alu_req_t                  req;
    logic signed [ACC_W-1:0]   alu_res;
    logic                      is_lad;
    logic                      is_clip;
    logic signed [10:0]        q_raw;
    logic [7:0]                q_use;
    logic signed [ACC_W-1:0]   x_ext;
    logic signed [TAP_W-1:0]   tap;
    logic signed [CMP_W-1:0]   tap_cmp;

    function automatic logic signed [ACC_W-1:0] clamp_acc(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] r;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

    msf_alu u_alu (
        .req (req),
        .res (alu_res)
    );

    // Model decode; code three runs as state variable
    assign is_lad  = (cfg.model == MODEL_LADDER);
    assign is_clip = (cfg.model == MODEL_CLIP);
    assign last_step = is_lad ? LAD_LAST : (is_clip ? CLIP_LAST : SVF_LAST);
    assign x_ext = ACC_W'(x_reg);

    // Damping with floor
    assign q_raw = 11'sd255 - $signed({2'b00, r_reg, 1'b0});
    assign q_use = (q_raw < $signed({3'b000, cfg.q_floor})) ? cfg.q_floor : q_raw[7:0];

    // ALU operand select per model and step
    always_comb
    begin
        req = '0;
        if (is_lad)
        begin
            unique case (step_reg)
                3'd0:
                begin
                    req.base = x_ext;
                    req.a    = ACC_W'(lad_reg[3]);
                    req.b    = MUL_B_W'({r_reg, 1'b0});
                    req.sub  = 1'b1;
                end
                3'd1:
                begin
                    req.base = ACC_W'(lad_reg[0]);
                    req.a    = tmp_reg - ACC_W'(lad_reg[0]);
                    req.b    = MUL_B_W'(c_reg);
                end
                3'd2:
                begin
                    req.base = ACC_W'(lad_reg[1]);
                    req.a    = ACC_W'(lad_reg[0]) - ACC_W'(lad_reg[1]);
                    req.b    = MUL_B_W'(c_reg);
                end
                3'd3:
                begin
                    req.base = ACC_W'(lad_reg[2]);
                    req.a    = ACC_W'(lad_reg[1]) - ACC_W'(lad_reg[2]);
                    req.b    = MUL_B_W'(c_reg);
                end
                default:
                begin
                    req.base = ACC_W'(lad_reg[3]);
                    req.a    = ACC_W'(lad_reg[2]) - ACC_W'(lad_reg[3]);
                    req.b    = MUL_B_W'(c_reg);
                end
            endcase
        end
        else if (is_clip)
        begin
            unique case (step_reg)
                3'd0:
                begin
                    req.base     = x_ext;
                    req.a        = ACC_W'(clip_reg[1]);
                    req.b        = MUL_B_W'(r_reg);
                    req.sub      = 1'b1;
                    req.fb_shift = 1'b1;
                end
                3'd1:
                begin
                    req.base = ACC_W'(clip_reg[0]);
                    req.a    = tmp_reg - ACC_W'(clip_reg[0]);
                    req.b    = MUL_B_W'(c_reg);
                end
                default:
                begin
                    req.base = ACC_W'(clip_reg[1]);
                    req.a    = ACC_W'(clip_reg[0]) - ACC_W'(clip_reg[1]);
                    req.b    = MUL_B_W'(c_reg);
                end
            endcase
        end
        else
        begin
            unique case (step_reg)
                3'd0:
                begin
                    req.base = ACC_W'(low_reg);
                    req.a    = ACC_W'(band_reg);
                    req.b    = MUL_B_W'(c_reg);
                end
                3'd1:
                begin
                    req.base = x_ext - ACC_W'(low_reg);
                    req.a    = ACC_W'(band_reg);
                    req.b    = MUL_B_W'(q_use);
                    req.sub  = 1'b1;
                end
                default:
                begin
                    req.base = ACC_W'(band_reg);
                    req.a    = tmp_reg;
                    req.b    = MUL_B_W'(c_reg);
                end
            endcase
        end
    end

    // Sequencer and state update
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        clr_next   = clr_reg;
        x_next     = x_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        tmp_next   = tmp_reg;
        low_next   = low_reg;
        band_next  = band_reg;
        lad_next   = lad_reg;
        clip_next  = clip_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    x_next    = item.sample_in;
                    c_next    = item.cutoff_coef;
                    r_next    = item.resonance_amount;
                    clr_next  = (item.action == ACT_CLEAR);
                    step_next = '0;
                    if (item.action == ACT_CLEAR)
                    begin
                        low_next  = '0;
                        band_next = '0;
                        for (int i = 0; i < LAD_POLES; i++) lad_next[i] = '0;
                        for (int i = 0; i < CLIP_POLES; i++) clip_next[i] = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (is_lad)
                begin
                    unique case (step_reg)
                        3'd0:    tmp_next    = clamp_acc(alu_res, LAD_MIN, LAD_MAX);
                        3'd1:    lad_next[0] = LAD_W'(alu_res);
                        3'd2:    lad_next[1] = LAD_W'(alu_res);
                        3'd3:    lad_next[2] = LAD_W'(alu_res);
                        default: lad_next[3] = LAD_W'(alu_res);
                    endcase
                end
                else if (is_clip)
                begin
                    unique case (step_reg)
                        3'd0:    tmp_next     = clamp_acc(alu_res, CLIP_MIN, CLIP_MAX);
                        3'd1:    clip_next[0] = CLIP_W'(alu_res);
                        default: clip_next[1] = CLIP_W'(alu_res);
                    endcase
                end
                else
                begin
                    unique case (step_reg)
                        3'd0:    low_next  = SVF_BITS'(clamp_acc(alu_res, SVF_LO, SVF_HI));
                        3'd1:    tmp_next  = alu_res;
                        default: band_next = SVF_BITS'(clamp_acc(alu_res, SVF_LO, SVF_HI));
                    endcase
                end

                if (step_reg == last_step) state_next = ST_OUT;
                else step_next = step_reg + STEP_W'(1);
            end
            ST_OUT:
            begin
                if (res_ready) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response tap
    always_comb
    begin
        tap = '0;
        if (clr_reg)
        begin
            tap = '0;
        end
        else if (is_lad)
        begin
            unique case (cfg.resp)
                RESP_HP:    tap = TAP_W'(x_reg) - TAP_W'(lad_reg[3]);
                RESP_BP:    tap = TAP_W'(lad_reg[2]) - TAP_W'(lad_reg[3]);
                RESP_NOTCH: tap = TAP_W'(x_reg) - TAP_W'(lad_reg[2]);
                default:    tap = TAP_W'(lad_reg[3]);
            endcase
        end
        else if (is_clip)
        begin
            unique case (cfg.resp)
                RESP_HP:    tap = TAP_W'(tmp_reg) - TAP_W'(clip_reg[0]);
                RESP_BP:    tap = TAP_W'(clip_reg[0]) - TAP_W'(clip_reg[1]);
                RESP_NOTCH: tap = TAP_W'(clip_reg[1]) + TAP_W'(tmp_reg)
                                  - TAP_W'(clip_reg[0]);
                default:    tap = TAP_W'(clip_reg[1]);
            endcase
        end
        else
        begin
            unique case (cfg.resp)
                RESP_HP:    tap = TAP_W'(tmp_reg);
                RESP_BP:    tap = TAP_W'(band_reg);
                RESP_NOTCH: tap = TAP_W'(low_reg) + TAP_W'(tmp_reg);
                default:    tap = TAP_W'(low_reg);
            endcase
        end
    end

    // Output saturation
    assign tap_cmp = CMP_W'(tap);
    always_comb
    begin
        if (tap_cmp > OUT_HI) res_data = OUT_W'(OUT_HI);
        else if (tap_cmp < OUT_LO) res_data = OUT_W'(OUT_LO);
        else res_data = OUT_W'(tap_cmp);
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_OUT);

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            clr_reg   <= 1'b0;
            low_reg   <= '0;
            band_reg  <= '0;
            for (int i = 0; i < LAD_POLES; i++) lad_reg[i] <= '0;
            for (int i = 0; i < CLIP_POLES; i++) clip_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
            low_reg   <= low_next;
            band_reg  <= band_next;
            lad_reg   <= lad_next;
            clip_reg  <= clip_next;
        end
    end

    // Request operands and scratch value
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        c_reg   <= c_next;
        r_reg   <= r_next;
        tmp_reg <= tmp_next;
    end

endmodule

// ===== rtl/multimode_synth_filter.sv =====
// ----------------------------------------------------------------------------
// multimode_synth_filter - three-model audio filter, top level
// APB registers, request/result channels and the filter core.
// ----------------------------------------------------------------------------
// Each request runs one sample through a single multiply-shift-add unit,
// one product per cycle. A request is accepted while idle, runs the
// model's steps (3 for state variable and two-pole, 5 for the ladder),
// then waits for the output register; a clear request skips them. The
// result goes to an output register, so the next request is taken while
// that result waits; ready stays low only while a request is in work or
// the output register is still full. Registers: model at 0x0, response at
// 0x4, damping floor at 0x8; write them only while the block is idle.
`include "multimode_synth_filter_assert.svh"

module multimode_synth_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msf_pkg::ADDR_W-1:0]    paddr,
    input  logic [msf_pkg::DATA_W-1:0]    pwdata,
    output logic [msf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    msf_in_if.sink                        in_ch,
    msf_out_if.source                     out_ch
);
    import msf_pkg::*;

    logic [1:0]              model_reg;
    logic [1:0]              resp_reg;
    logic [7:0]              qfloor_reg;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    cfg_t                    cfg;
    item_t                   item;
    core_stat_t              core_stat;
    logic signed [OUT_W-1:0] core_data;
    logic                    core_res_ready;
    logic                    core_res_load;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg  <= MODEL_SVF;
            resp_reg   <= RESP_LP;
            qfloor_reg <= QFLOOR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MODEL:  model_reg  <= pwdata[1:0];
                REG_RESP:   resp_reg   <= pwdata[1:0];
                REG_QFLOOR: qfloor_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODEL:  prdata = DATA_W'(model_reg);
            REG_RESP:   prdata = DATA_W'(resp_reg);
            REG_QFLOOR: prdata = DATA_W'(qfloor_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.model   = model_reg;
    assign cfg.resp    = resp_reg;
    assign cfg.q_floor = qfloor_reg;

    // Request side
    assign item.action           = in_ch.action;
    assign item.sample_in        = in_ch.sample_in;
    assign item.cutoff_coef      = in_ch.cutoff_coef;
    assign item.resonance_amount = in_ch.resonance_amount;
    assign in_ch.ready           = core_stat.idle;

    msf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_ch.valid),
        .item       (item),
        .stat       (core_stat),
        .res_data   (core_data),
        .res_ready  (core_res_ready)
    );

    // Output register
    assign core_res_ready = !out_valid_reg || out_ch.ready;
    assign core_res_load  = core_stat.res_valid && core_res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_load) out_data_reg <= core_data;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

    // Checks
    `MSF_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    `MSF_ASSERT_NEXT(a_result_loaded, clk, rst_n, core_res_load, out_ch.valid)
    `MSF_ASSERT_IMPL(a_no_req_with_result, clk, rst_n, core_stat.res_valid, !in_ch.ready)

endmodule

// ===== test/tb_multimode_synth_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multimode_synth_filter - self-checking bench for the multimode filter
// Streams sample requests through the block under changing model, response
// and damping-floor settings. A local fixed-point copy of the three filter
// models predicts every output sample. Results are compared in order, and
// both channels idle at random.
// ----------------------------------------------------------------------------
module tb_multimode_synth_filter;
    import msf_pkg::*;

    localparam int    CYCLE_LIMIT = 600000;
    localparam int    MAX_REPORTS = 10;
    localparam int    SEGMENTS    = 24;
    localparam int    SEG_ITEMS   = 80;
    localparam longint INTEG_MAX  = (64'sd1 <<< 23) - 1;
    localparam longint INTEG_MIN  = -(64'sd1 <<< 23);
    localparam longint RESULT_MAX = (64'sd1 <<< 24) - 1;
    localparam longint RESULT_MIN = -(64'sd1 <<< 24);

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    msf_in_if  req_if ();
    msf_out_if res_if ();

    multimode_synth_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (req_if),
        .out_ch  (res_if)
    );

    // Requests waiting to be sent, output samples waiting to arrive
    item_t                   pending_reqs[$];
    logic signed [OUT_W-1:0] expected_out[$];
    item_t                   next_req;

    int n_queued    = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int cycle_count = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 81;

    // Shadow of the registers and of the filter state
    logic [1:0] cfg_model;
    logic [1:0] cfg_resp;
    logic [7:0] cfg_qfloor;
    longint     svf_lp_acc;
    longint     svf_bp_acc;
    longint     lad_pole[4];
    longint     clp_pole[2];

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void clear_filter_state();
        svf_lp_acc = 0;
        svf_bp_acc = 0;
        for (int i = 0; i < 4; i++)
            lad_pole[i] = 0;
        clp_pole[0] = 0;
        clp_pole[1] = 0;
    endfunction

    // One sample through the selected model; updates the shadow state
    function automatic logic signed [OUT_W-1:0] predict_filtered(
        input logic               act,
        input logic signed [15:0] smp,
        input logic [7:0]         coef,
        input logic [7:0]         reso
    );
        longint x, c, r, q, u, hp, y;
        x = smp;
        c = coef;
        r = reso;
        if (act == ACT_CLEAR)
        begin
            clear_filter_state();
            return '0;
        end
        case (cfg_model)
            MODEL_LADDER:
            begin
                u = clamp_to(x - ((lad_pole[3] * (2 * r)) >>> 8), -256, 255);
                lad_pole[0] = lad_pole[0] + (((u - lad_pole[0]) * c) >>> 8);
                for (int i = 1; i < 4; i++)
                    lad_pole[i] = lad_pole[i] + (((lad_pole[i-1] - lad_pole[i]) * c) >>> 8);
                case (cfg_resp)
                    RESP_HP:    y = x - lad_pole[3];
                    RESP_BP:    y = lad_pole[2] - lad_pole[3];
                    RESP_NOTCH: y = x - lad_pole[2];
                    default:    y = lad_pole[3];
                endcase
            end
            MODEL_CLIP:
            begin
                u = clamp_to(x - ((clp_pole[1] * r) >>> 7), -200, 180);
                clp_pole[0] = clp_pole[0] + (((u - clp_pole[0]) * c) >>> 8);
                clp_pole[1] = clp_pole[1] + (((clp_pole[0] - clp_pole[1]) * c) >>> 8);
                case (cfg_resp)
                    RESP_HP:    y = u - clp_pole[0];
                    RESP_BP:    y = clp_pole[0] - clp_pole[1];
                    RESP_NOTCH: y = clp_pole[1] + (u - clp_pole[0]);
                    default:    y = clp_pole[1];
                endcase
            end
            default:
            begin
                // state variable; the spare model code lands here too
                q = 255 - 2 * r;
                if (q < longint'(cfg_qfloor))
                    q = longint'(cfg_qfloor);
                svf_lp_acc = clamp_to(svf_lp_acc + ((c * svf_bp_acc) >>> 8),
                                      INTEG_MIN, INTEG_MAX);
                hp = x - svf_lp_acc - ((q * svf_bp_acc) >>> 8);
                svf_bp_acc = clamp_to(svf_bp_acc + ((c * hp) >>> 8), INTEG_MIN, INTEG_MAX);
                case (cfg_resp)
                    RESP_HP:    y = hp;
                    RESP_BP:    y = svf_bp_acc;
                    RESP_NOTCH: y = svf_lp_acc + hp;
                    default:    y = svf_lp_acc;
                endcase
            end
        endcase
        y = clamp_to(y, RESULT_MIN, RESULT_MAX);
        return y[OUT_W-1:0];
    endfunction

    task automatic push_req(input logic act, input logic [15:0] smp,
                            input logic [7:0] coef, input logic [7:0] reso);
        item_t it;
        it.action           = act;
        it.sample_in        = smp;
        it.cutoff_coef      = coef;
        it.resonance_amount = reso;
        pending_reqs.push_back(it);
        n_queued++;
    endtask

    // Coefficient with the extremes weighted up
    function automatic logic [7:0] pick_coef();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        return 8'($urandom);
    endfunction

    // Bursts with held coefficients and a shaped input, mixed with noise
    task automatic queue_bursts(input int n_items);
        int               left;
        int               len;
        int               style;
        logic [15:0]      lvl;
        logic [15:0]      x;
        logic [7:0]       c;
        logic [7:0]       r;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(1, 36);
            if (len > left)
                len = left;
            c = pick_coef();
            r = pick_coef();
            style = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                lvl = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
            else
                lvl = 16'($urandom);
            for (int k = 0; k < len; k++)
            begin
                case (style)
                    0:       x = lvl;
                    1:       x = ((k / 4) % 2 == 1) ? lvl : ~lvl;
                    2:       x = lvl + 16'($urandom_range(0, 63)) - 16'd32;
                    default: x = 16'($urandom);
                endcase
                if ($urandom_range(0, 99) < 2)
                    push_req(ACT_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom));
                else if (style == 4)
                    push_req(ACT_PROCESS, 16'($urandom), 8'($urandom), 8'($urandom));
                else
                    push_req(ACT_PROCESS, x, c, r);
            end
            left -= len;
        end
    endtask

    // Block until every queued request has produced its checked result
    task automatic wait_drained();
        while (n_checked != n_queued)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODEL:  cfg_model  = value[1:0];
            REG_RESP:   cfg_resp   = value[1:0];
            REG_QFLOOR: cfg_qfloor = value;
            default:    ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (n_errors < MAX_REPORTS)
            $display("ERROR %s: expected %0d got %0d (cycle %0d)", what,
                     $signed(want), $signed(got), cycle_count);
        n_errors++;
    endtask

    // Request driver: predicts on acceptance, then offers the next request
    always @(posedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_out.push_back(predict_filtered(req_if.action, req_if.sample_in,
                                                        req_if.cutoff_coef,
                                                        req_if.resonance_amount));
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    req_if.valid            <= 1'b1;
                    req_if.action           <= next_req.action;
                    req_if.sample_in        <= next_req.sample_in;
                    req_if.cutoff_coef      <= next_req.cutoff_coef;
                    req_if.resonance_amount <= next_req.resonance_amount;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_out.size() == 0)
                    note_mismatch("unexpected result", 'x, res_if.sample_out);
                else
                begin
                    if (res_if.sample_out !== expected_out[0])
                        note_mismatch("sample_out", expected_out[0], res_if.sample_out);
                    void'(expected_out.pop_front());
                    n_checked++;
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        req_if.valid            = 1'b0;
        req_if.action           = ACT_PROCESS;
        req_if.sample_in        = '0;
        req_if.cutoff_coef      = '0;
        req_if.resonance_amount = '0;
        res_if.ready            = 1'b0;
        cfg_model  = MODEL_SVF;
        cfg_resp   = RESP_LP;
        cfg_qfloor = QFLOOR_RESET;
        clear_filter_state();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and clears at the reset settings
        push_req(ACT_CLEAR,   16'hFFFF, 8'd255, 8'd255);
        push_req(ACT_PROCESS, 16'h7FFF, 8'd255, 8'd0);
        repeat (4) push_req(ACT_PROCESS, 16'h7FFF, 8'd255, 8'd255);
        repeat (4) push_req(ACT_PROCESS, 16'h8000, 8'd255, 8'd255);
        push_req(ACT_PROCESS, 16'h0000, 8'd0,   8'd0);
        push_req(ACT_PROCESS, 16'hFFFF, 8'd128, 8'd128);
        push_req(ACT_PROCESS, 16'h8000, 8'd0,   8'd255);
        push_req(ACT_CLEAR,   16'h0000, 8'd0,   8'd0);
        push_req(ACT_PROCESS, 16'h7FFF, 8'd1,   8'd0);
        repeat (3) push_req(ACT_PROCESS, 16'h8000, 8'd200, 8'd127);
        push_req(ACT_PROCESS, 16'h5555, 8'd170, 8'd85);
        push_req(ACT_PROCESS, 16'hAAAA, 8'd85,  8'd170);
        push_req(ACT_CLEAR,   16'h7FFF, 8'd0,   8'd0);
        push_req(ACT_PROCESS, 16'h0001, 8'd255, 8'd255);

        // Random segments: every model/response pair, extreme and random damping floors
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            case (seg / 8)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(REG_MODEL, 8'(seg % 4));
            write_reg(REG_RESP, 8'((seg / 4) % 4));
            case (seg % 3)
                0:       write_reg(REG_QFLOOR, 8'd0);
                1:       write_reg(REG_QFLOOR, 8'd255);
                default: write_reg(REG_QFLOOR, 8'($urandom_range(1, 254)));
            endcase
            if (seg == 3)
            begin
                // hold off the sender until the pipeline is empty
                queue_bursts(SEG_ITEMS / 2);
                wait_drained();
                queue_bursts(SEG_ITEMS / 2);
            end
            else
                queue_bursts(SEG_ITEMS);
        end

        while (n_checked != n_queued)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0 && expected_out.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
